// ===== rtl/core/ajb_pkg.sv =====
// ----------------------------------------------------------------------------
// ajb_pkg
// Shared types, constants and pointer helpers for the audio jitter buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ajb_pkg;

   localparam int RING_DEPTH  = 4096;
   localparam int PTR_W       = $clog2(RING_DEPTH);
   localparam int FILL_W      = 12;
   localparam int CMP_W       = (PTR_W > FILL_W) ? PTR_W : FILL_W;
   localparam int SMP_W       = 16;
   localparam int FRAME_W     = 10;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(RING_DEPTH - 1);
   localparam logic [PTR_W-1:0]   DEPTH_PTR = PTR_W'(RING_DEPTH);
   localparam logic [FILL_W-1:0]  FILL_MAX  = '1;

   localparam logic [FILL_W-1:0]  PRIME_LEVEL_RST = 12'd2880;
   localparam logic [FRAME_W-1:0] FRAME_MAX_RST   = 10'd960;

   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_PULL  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic REG_PRIME_LEVEL = 1'b0;
   localparam logic REG_FRAME_MAX   = 1'b1;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ
   } op_kind_type;

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [SMP_W-1:0] sample;
      logic                    frame_start;
      logic [FILL_W-1:0]       frame_len;
   } req_type;

   typedef struct packed {
      logic signed [SMP_W-1:0] out_sample;
      logic                    accepted;
      logic                    padded;
      logic                    frame_last;
      logic [FILL_W-1:0]       fill_level;
   } rsp_type;

   typedef struct packed {
      op_kind_type             kind;
      logic [PTR_W-1:0]        addr;
      logic signed [SMP_W-1:0] wdata;
      logic                    accepted;
      logic                    padded;
      logic                    frame_last;
      logic [FILL_W-1:0]       fill_level;
   } op_type;

   function automatic logic [PTR_W-1:0] ring_fill(input logic [PTR_W-1:0] wp,
                                                  input logic [PTR_W-1:0] rp);
      logic [PTR_W-1:0] res;
      if (wp >= rp) begin
         res = wp - rp;
      end else begin
         res = wp + DEPTH_PTR - rp;
      end
      return res;
   endfunction

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] res;
      if (p == LAST_PTR) begin
         res = '0;
      end else begin
         res = p + PTR_W'(1);
      end
      return res;
   endfunction

   function automatic logic [FILL_W-1:0] sat_fill(input logic [PTR_W-1:0] f);
      logic [PTR_W+FILL_W-1:0] wide;
      logic [FILL_W-1:0]       res;
      wide = (PTR_W+FILL_W)'(f);
      if (wide > (PTR_W+FILL_W)'(FILL_MAX)) begin
         res = FILL_MAX;
      end else begin
         res = wide[FILL_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ajb_front.sv =====
// ----------------------------------------------------------------------------
// ajb_front
// Accepts items, keeps pointers, priming and frame state, holds the
// configuration registers and issues one queue operation per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire ajb_pkg::req_type              req_payload,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [ajb_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [ajb_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [ajb_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready,
   input  wire logic                          q_full,
   output logic                               q_push,
   output ajb_pkg::op_type                    q_op
);
   import ajb_pkg::*;

   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [PTR_W-1:0]   rp_ff, rp_in;
   logic               primed_ff, primed_in;
   logic [FRAME_W-1:0] grant_ff, grant_in;
   logic [FRAME_W-1:0] size_ff, size_in;
   logic [FRAME_W-1:0] pos_ff, pos_in;
   logic [FILL_W-1:0]  prime_level_ff;
   logic [FRAME_W-1:0] frame_max_ff;

   logic               accept;
   logic               csr_write;
   logic [PTR_W-1:0]   fill_cur;
   logic [CMP_W-1:0]   have_ext;
   logic [FRAME_W-1:0] fm;
   logic [FILL_W-1:0]  len_req;
   logic [FRAME_W-1:0] len_clamped;
   logic [FRAME_W-1:0] grant_new;
   logic               primed_now;

   assign req_stall  = q_full;
   assign accept     = req_valid && !q_full;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign fill_cur   = ring_fill(wp_ff, rp_ff);
   assign have_ext   = CMP_W'(fill_cur);

   always_comb begin
      if (csr_paddr[2] == REG_FRAME_MAX) begin
         csr_prdata = CSR_DW'(frame_max_ff);
      end else begin
         csr_prdata = CSR_DW'(prime_level_ff);
      end
   end

   always_comb begin
      fm          = (frame_max_ff == '0) ? FRAME_W'(1) : frame_max_ff;
      len_req     = (req_payload.frame_len == '0) ? FILL_W'(1) : req_payload.frame_len;
      len_clamped = (len_req > FILL_W'(fm)) ? fm : len_req[FRAME_W-1:0];
      primed_now  = primed_ff || (have_ext >= CMP_W'(prime_level_ff));
      if (have_ext < CMP_W'(len_clamped)) begin
         grant_new = have_ext[FRAME_W-1:0];
      end else begin
         grant_new = len_clamped;
      end
   end

   always_comb begin
      logic [FRAME_W-1:0] g;
      logic [FRAME_W-1:0] s;
      logic [FRAME_W-1:0] p;
      logic               pr;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      primed_in = primed_ff;
      grant_in  = grant_ff;
      size_in   = size_ff;
      pos_in    = pos_ff;
      g         = grant_ff;
      s         = size_ff;
      p         = pos_ff;
      pr        = primed_ff;
      q_op            = '0;
      q_op.kind       = OP_NONE;
      q_op.addr       = wp_ff;
      q_op.wdata      = req_payload.sample;
      case (req_payload.mode)
         MODE_PUSH: begin
            if (fill_cur != LAST_PTR) begin
               wp_in         = ring_next(wp_ff);
               q_op.kind     = OP_WRITE;
               q_op.accepted = 1'b1;
            end
         end
         MODE_PULL: begin
            if (req_payload.frame_start) begin
               if (primed_now) begin
                  g  = grant_new;
                  pr = (grant_new >= len_clamped);
               end else begin
                  g  = '0;
                  pr = 1'b0;
               end
               s = len_clamped;
               p = '0;
            end
            if (p < s) begin
               if (p < g && fill_cur != '0) begin
                  rp_in     = ring_next(rp_ff);
                  q_op.kind = OP_READ;
                  q_op.addr = rp_ff;
               end else begin
                  q_op.padded = 1'b1;
               end
               q_op.frame_last = (p + FRAME_W'(1) == s);
               p = p + FRAME_W'(1);
            end else begin
               q_op.padded = 1'b1;
            end
            grant_in  = g;
            size_in   = s;
            pos_in    = p;
            primed_in = pr;
         end
         MODE_CLEAR: begin
            rp_in     = wp_ff;
            primed_in = 1'b0;
            if (grant_ff > pos_ff) begin
               grant_in = pos_ff;
            end
         end
         default: begin
         end
      endcase
      q_op.fill_level = sat_fill(ring_fill(wp_in, rp_in));
      q_push          = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff          <= '0;
         rp_ff          <= '0;
         primed_ff      <= 1'b0;
         grant_ff       <= '0;
         size_ff        <= '0;
         pos_ff         <= '0;
         prime_level_ff <= PRIME_LEVEL_RST;
         frame_max_ff   <= FRAME_MAX_RST;
      end else begin
         if (accept) begin
            wp_ff     <= wp_in;
            rp_ff     <= rp_in;
            primed_ff <= primed_in;
            grant_ff  <= grant_in;
            size_ff   <= size_in;
            pos_ff    <= pos_in;
         end
         if (csr_write) begin
            if (csr_paddr[2] == REG_PRIME_LEVEL) begin
               prime_level_ff <= csr_pwdata[FILL_W-1:0];
            end else begin
               frame_max_ff <= csr_pwdata[FRAME_W-1:0];
            end
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_cur <= LAST_PTR)
      else $error("ring holds more than its capacity");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= size_ff)
      else $error("frame position beyond frame size");

   a_grant_bound: assert property (@(posedge clock) disable iff (reset)
      grant_ff <= size_ff)
      else $error("frame grant beyond frame size");

endmodule

`default_nettype wire

// ===== rtl/core/ajb_queue.sv =====
// ----------------------------------------------------------------------------
// ajb_queue
// Short register queue of ring operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire ajb_pkg::op_type push_op,
   output logic                 full,
   input  wire logic            pop,
   output logic                 not_empty,
   output ajb_pkg::op_type      head_op
);
   import ajb_pkg::*;

   op_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_pop;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_op   = slot_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = push ? ((wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1)) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1))
                      : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/ajb_back.sv =====
// ----------------------------------------------------------------------------
// ajb_back
// Carries out ring writes and reads on the sample memory and holds the
// result word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_not_empty,
   input  wire ajb_pkg::op_type q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output ajb_pkg::rsp_type     rsp_payload
);
   import ajb_pkg::*;

   logic signed [SMP_W-1:0] ring_mem [RING_DEPTH];
   logic signed [SMP_W-1:0] rd_data_ff;
   logic                    valid_ff;
   logic                    is_read_ff;
   logic                    accepted_ff;
   logic                    padded_ff;
   logic                    last_ff;
   logic [FILL_W-1:0]       fill_ff;

   assign q_pop = q_not_empty && (!valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (q_pop && q_head.kind == OP_WRITE) begin
         ring_mem[q_head.addr] <= q_head.wdata;
      end
      if (q_pop && q_head.kind == OP_READ) begin
         rd_data_ff <= ring_mem[q_head.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         is_read_ff  <= (q_head.kind == OP_READ);
         accepted_ff <= q_head.accepted;
         padded_ff   <= q_head.padded;
         last_ff     <= q_head.frame_last;
         fill_ff     <= q_head.fill_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid              = valid_ff;
   assign rsp_payload.out_sample = is_read_ff ? rd_data_ff : '0;
   assign rsp_payload.accepted   = accepted_ff;
   assign rsp_payload.padded     = padded_ff;
   assign rsp_payload.frame_last = last_ff;
   assign rsp_payload.fill_level = fill_ff;

   a_no_pop_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |-> !q_pop)
      else $error("queue popped while result word is held");

   a_read_not_padded: assert property (@(posedge clock) disable iff (reset)
      valid_ff && is_read_ff |-> !padded_ff && !accepted_ff)
      else $error("ring read flagged as padding or push");

   a_hold_read: assert property (@(posedge clock) disable iff (reset)
      $past(valid_ff && rsp_stall) && !$past(reset) |-> $stable(rd_data_ff))
      else $error("read data changed while result word is held");

endmodule

`default_nettype wire

// ===== rtl/core/audio_jitter_buffer_core.sv =====
// ----------------------------------------------------------------------------
// audio_jitter_buffer_core
// Jitter buffer for 16-bit mono voice samples: front control, operation
// queue and sample memory back end.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle on each side while the consumer does not stall.
// An accepted item's result word passes through the operation queue and then the
// registered read of the sample memory before it is valid.
// A four-entry queue between front and back absorbs consumer stalls.
// Reset clears pointers, priming, frame state and the queue, and loads the
// register defaults; ring contents are not cleared and no sweep is needed.
`default_nettype none

module audio_jitter_buffer_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire ajb_pkg::req_type              req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output ajb_pkg::rsp_type                   rsp_payload,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [ajb_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [ajb_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [ajb_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready
);
   import ajb_pkg::*;

   logic   q_full;
   logic   q_push;
   logic   q_pop;
   logic   q_not_empty;
   op_type q_in_op;
   op_type q_head;

   ajb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_op        (q_in_op)
   );

   ajb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (q_in_op),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_op   (q_head)
   );

   ajb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
